// ===== hdl/gnc_pkg.sv =====
package gnc_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int LIMIT_W       = 4;
  localparam int TOTAL_W       = 24;
  localparam int NUM_BANKS     = 3;
  localparam int BANK_W        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

  typedef logic [BANK_W-1:0] bank_t;

  typedef enum logic [1:0] {
    KIND_CELL     = 2'd0,
    KIND_ROW_END  = 2'd1,
    KIND_GRID_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // one column entering the window stage
  typedef struct packed {
    logic  vld;
    logic  flush;
    logic  first;
    logic  below;
    logic  above_ok;
    logic  mid_ok;
    bank_t above_sel;
    bank_t mid_sel;
  } issue_t;

endpackage

// ===== hdl/gnc_line_ram.sv =====
module gnc_line_ram #(
  parameter  int DEPTH  = gnc_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic [gnc_pkg::NUM_BANKS-1:0] we,
  input  logic [ADDR_W-1:0]             addr,
  input  logic                          wdata,
  output logic [gnc_pkg::NUM_BANKS-1:0] rdata
);

  // one bit lane per row buffer, written through a per-lane enable
  logic [gnc_pkg::NUM_BANKS-1:0] mem_r [DEPTH];
  logic [gnc_pkg::NUM_BANKS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    for (int b = 0; b < gnc_pkg::NUM_BANKS; b++) begin
      if (we[b]) begin
        mem_r[addr][b] <= wdata;
      end
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gnc_judge.sv =====
module gnc_judge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gnc_pkg::issue_t              issue,
  input  logic [gnc_pkg::NUM_BANKS-1:0] rd_data,
  input  logic [gnc_pkg::LIMIT_W-1:0]  limit,
  input  logic                         emit,
  output logic                         judge_busy,
  output logic [gnc_pkg::TOTAL_W-1:0]  total
);

  // window columns: [2] above, [1] middle, [0] below
  logic [2:0]                    col_in;
  logic [2:0]                    win1_r;
  logic [2:0]                    win2_r;
  logic                          judge_en;
  logic [gnc_pkg::LIMIT_W-1:0]   nbr_cnt;
  logic                          hit;
  logic                          hit_r;
  logic                          hit_vld_r;
  logic [gnc_pkg::TOTAL_W-1:0]   total_r;

  always_comb begin
    if (issue.flush) begin
      col_in = 3'b000;
    end else begin
      col_in = {issue.above_ok & rd_data[issue.above_sel],
                issue.mid_ok & rd_data[issue.mid_sel],
                issue.below};
    end
    judge_en = issue.vld && (issue.flush || !issue.first);
    nbr_cnt  = gnc_pkg::LIMIT_W'(win2_r[2]) + gnc_pkg::LIMIT_W'(win2_r[1])
             + gnc_pkg::LIMIT_W'(win2_r[0]) + gnc_pkg::LIMIT_W'(col_in[2])
             + gnc_pkg::LIMIT_W'(col_in[1]) + gnc_pkg::LIMIT_W'(col_in[0])
             + gnc_pkg::LIMIT_W'(win1_r[2]) + gnc_pkg::LIMIT_W'(win1_r[0]);
    hit      = win1_r[1] && (nbr_cnt < limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vld_r <= 1'b0;
      total_r   <= '0;
    end else begin
      hit_vld_r <= judge_en;
      if (emit) begin
        total_r <= '0;
      end else if (hit_vld_r && hit_r && (total_r != '1)) begin
        total_r <= total_r + gnc_pkg::TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit;
    if (issue.vld && !issue.flush) begin
      win1_r <= col_in;
      win2_r <= issue.first ? 3'b000 : win1_r;
    end
  end

  assign judge_busy = issue.vld || hit_vld_r;
  assign total      = total_r;

endmodule

// ===== hdl/gnc_ctrl.sv =====
module gnc_ctrl #(
  parameter  int MAX_WIDTH = gnc_pkg::MAX_WIDTH_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH + 1),
  localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic                          in_occupied,
  input  logic                          judge_busy,
  input  logic                          out_free,
  output logic                          emit,
  output logic [gnc_pkg::NUM_BANKS-1:0] mem_we,
  output logic [ADDR_W-1:0]             mem_addr,
  output logic                          mem_wdata,
  output gnc_pkg::issue_t               issue_r
);

  gnc_pkg::state_t  state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] w_above_r, w_above_nxt;
  logic [COL_W-1:0] w_mid_r, w_mid_nxt;
  logic [COL_W-1:0] k_r, k_nxt;
  gnc_pkg::bank_t   rot_r, rot_nxt;
  gnc_pkg::issue_t  issue_nxt;
  gnc_pkg::bank_t   mid_bank;
  gnc_pkg::bank_t   above_bank;
  logic             accept;

  function automatic gnc_pkg::bank_t bank_prev(gnc_pkg::bank_t b);
    return (b == '0) ? gnc_pkg::bank_t'(gnc_pkg::NUM_BANKS - 1) : b - gnc_pkg::bank_t'(1);
  endfunction

  function automatic gnc_pkg::bank_t bank_next(gnc_pkg::bank_t b);
    return (b == gnc_pkg::bank_t'(gnc_pkg::NUM_BANKS - 1)) ? '0 : b + gnc_pkg::bank_t'(1);
  endfunction

  assign mid_bank   = bank_prev(rot_r);
  assign above_bank = bank_prev(mid_bank);
  assign accept     = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gnc_pkg::ST_RUN: begin
        if (accept && (in_kind == gnc_pkg::KIND_GRID_END)) begin
          state_nxt = ((col_r != '0) || (w_mid_r != '0)) ? gnc_pkg::ST_SWEEP
                                                          : gnc_pkg::ST_DRAIN;
        end
      end
      gnc_pkg::ST_SWEEP: begin
        if (k_r == w_mid_r) begin
          state_nxt = gnc_pkg::ST_DRAIN;
        end
      end
      gnc_pkg::ST_DRAIN: begin
        if (!judge_busy) begin
          state_nxt = gnc_pkg::ST_EMIT;
        end
      end
      gnc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = gnc_pkg::ST_RUN;
        end
      end
      default: state_nxt = gnc_pkg::ST_RUN;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall    = (state_r != gnc_pkg::ST_RUN);
    emit        = 1'b0;
    mem_we      = '0;
    mem_addr    = col_r[ADDR_W-1:0];
    mem_wdata   = in_occupied;
    issue_nxt   = '0;
    col_nxt     = col_r;
    w_above_nxt = w_above_r;
    w_mid_nxt   = w_mid_r;
    k_nxt       = k_r;
    rot_nxt     = rot_r;
    unique case (state_r)
      gnc_pkg::ST_RUN: begin
        if (accept) begin
          unique case (in_kind) inside
            gnc_pkg::KIND_CELL: begin
              if (col_r < COL_W'(MAX_WIDTH)) begin
                mem_we[rot_r]      = 1'b1;
                issue_nxt.vld      = 1'b1;
                issue_nxt.first    = (col_r == '0);
                issue_nxt.below    = in_occupied;
                issue_nxt.above_ok = (col_r < w_above_r);
                issue_nxt.mid_ok   = (col_r < w_mid_r);
                issue_nxt.above_sel = above_bank;
                issue_nxt.mid_sel  = mid_bank;
                col_nxt            = col_r + COL_W'(1);
              end
            end
            gnc_pkg::KIND_ROW_END, gnc_pkg::KIND_GRID_END: begin
              k_nxt = '0;
              if (col_r != '0) begin
                issue_nxt.vld   = 1'b1;
                issue_nxt.flush = 1'b1;
                rot_nxt         = bank_next(rot_r);
                w_above_nxt     = w_mid_r;
                w_mid_nxt       = col_r;
                col_nxt         = '0;
              end
            end
            default: ;
          endcase
        end
      end
      gnc_pkg::ST_SWEEP: begin
        // last row against an empty row below
        mem_addr = k_r[ADDR_W-1:0];
        if (k_r == w_mid_r) begin
          issue_nxt.vld   = 1'b1;
          issue_nxt.flush = 1'b1;
        end else begin
          issue_nxt.vld       = 1'b1;
          issue_nxt.first     = (k_r == '0);
          issue_nxt.above_ok  = (k_r < w_above_r);
          issue_nxt.mid_ok    = 1'b1;
          issue_nxt.above_sel = above_bank;
          issue_nxt.mid_sel   = mid_bank;
          k_nxt               = k_r + COL_W'(1);
        end
      end
      gnc_pkg::ST_DRAIN: ;
      gnc_pkg::ST_EMIT: begin
        if (out_free) begin
          emit        = 1'b1;
          col_nxt     = '0;
          w_above_nxt = '0;
          w_mid_nxt   = '0;
          rot_nxt     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gnc_pkg::ST_RUN;
      col_r     <= '0;
      w_above_r <= '0;
      w_mid_r   <= '0;
      k_r       <= '0;
      rot_r     <= '0;
      issue_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      w_above_r <= w_above_nxt;
      w_mid_r   <= w_mid_nxt;
      k_r       <= k_nxt;
      rot_r     <= rot_nxt;
      issue_r   <= issue_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_bank_written: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mem_we))
    else $error("more than one line bank written");

  a_no_write_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gnc_pkg::ST_RUN) |-> (mem_we == '0))
    else $error("line bank written outside run state");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !judge_busy)
    else $error("total emitted with columns in flight");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(MAX_WIDTH))
    else $error("column position past line length");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gnc_pkg::ST_SWEEP) |-> (k_r <= w_mid_r))
    else $error("sweep index past last row width");
`endif

endmodule

// ===== hdl/grid_neighbor_count_stream.sv =====
// Binary grid accessible-cell counter.
// Input channel (in_valid/in_stall): one transaction per cell in raster order,
// in_kind = cell, end of row or end of grid; in_occupied marks a set cell.
// Result channel (out_valid/out_stall): one transaction per grid, carrying the
// saturating count of occupied cells with fewer than cfg neighbors set.
// cfg_wr_en/cfg_wr_data write the neighbor limit; write only while idle.
// Cells and row ends cause no stall and are taken one per clock outside
// the end-of-grid stall; each cell passes through a single-port line RAM
// that holds the three row buffers as bit lanes, with a registered read.
// An end of grid closes the last row, then that row, if any, is swept once
// against an empty row below; input stalls through the sweep, the drain of
// the window stage and any wait for a free output register. The result is
// loaded once the window stage has drained and then clears the count for
// the next grid; the next grid's cells are taken while the result still
// waits. A stalled result holds in the output register; a second end of
// grid waits until that register is free. Reset (rst_n low, synchronous)
// empties the grid, drops any result and sets the limit to 4; no RAM
// clearing pass.
module grid_neighbor_count_stream #(
  parameter int MAX_WIDTH = gnc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic                         in_occupied,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gnc_pkg::TOTAL_W-1:0]  out_accessible_total,
  input  logic                         cfg_wr_en,
  input  logic [gnc_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  logic [gnc_pkg::LIMIT_W-1:0]   limit_r;
  logic                          out_valid_r;
  logic [gnc_pkg::TOTAL_W-1:0]   out_total_r;
  logic                          out_free;
  logic                          emit;
  logic                          judge_busy;
  logic [gnc_pkg::NUM_BANKS-1:0] mem_we;
  logic [ADDR_W-1:0]             mem_addr;
  logic                          mem_wdata;
  logic [gnc_pkg::NUM_BANKS-1:0] rd_data;
  gnc_pkg::issue_t               issue;
  logic [gnc_pkg::TOTAL_W-1:0]   total;

  assign out_free = !out_valid_r || !out_stall;

  gnc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_occupied (in_occupied),
    .judge_busy  (judge_busy),
    .out_free    (out_free),
    .emit        (emit),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .issue_r     (issue)
  );

  gnc_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_data)
  );

  gnc_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .rd_data    (rd_data),
    .limit      (limit_r),
    .emit       (emit),
    .judge_busy (judge_busy),
    .total      (total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= gnc_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_total_r <= total;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accessible_total = out_total_r;

`ifndef NO_ASSERTIONS
  a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over an unaccepted result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result appeared without an emit");

  a_input_held_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> in_stall)
    else $error("input taken while emitting a result");
`endif

endmodule
